### hdl/ipu_pkg.sv
// ----------------------------------------------------------------------------
// ipu_pkg
// Shared types, constants and fixed-point helpers of the undistortion core.
// ----------------------------------------------------------------------------
`default_nettype none

package ipu_pkg;

  // number of unrolled refinement steps
  localparam int unsigned Iterations = 5;

  // pipelined divider geometry: one quotient bit per stage
  localparam int unsigned DivNumW   = 33;
  localparam int unsigned DivDenW   = 32;
  localparam int unsigned DivStages = DivNumW;

  localparam int unsigned RndW = 51;  // rounded Q.16 product
  localparam int unsigned WideW = 52; // operand of a clamp

  localparam logic signed [WideW-1:0] WideMidMax = 52'sd2147483647;
  localparam logic signed [WideW-1:0] WideMidMin = -52'sd2147483648;
  localparam logic signed [WideW-1:0] WideOutMax = 52'sd524287;
  localparam logic signed [WideW-1:0] WideOutMin = -52'sd524288;
  localparam logic signed [WideW-1:0] WideOne    = 52'sd65536;

  // configuration register indexes
  typedef enum logic [2:0] {
    RegCenterX = 3'd0,
    RegCenterY = 3'd1,
    RegFocalX  = 3'd2,
    RegFocalY  = 3'd3,
    RegK1      = 3'd4,
    RegK2      = 3'd5,
    RegP1      = 3'd6,
    RegP2      = 3'd7
  } ipu_reg_e;

  typedef struct packed {
    logic signed [19:0] k1;
    logic signed [19:0] k2;
    logic signed [19:0] p1;
    logic signed [19:0] p2;
  } ipu_coef_t;

  // one point in flight between refinement steps
  typedef struct packed {
    logic               vld;
    logic               sat;
    logic signed [19:0] xd;
    logic signed [19:0] yd;
    logic signed [19:0] x;
    logic signed [19:0] y;
  } ipu_item_t;

  typedef struct packed {
    logic               sat;
    logic signed [31:0] val;
  } ipu_c32_t;

  typedef struct packed {
    logic               sat;
    logic signed [19:0] val;
  } ipu_c20_t;

  // Q.16 product, rounded half away from zero
  function automatic logic signed [RndW-1:0] mulq(input logic signed [32:0] a,
                                                   input logic signed [32:0] b);
    logic signed [65:0] p;
    logic [65:0]        mag;
    logic [RndW-2:0]    m;
    p   = a * b;
    mag = p[65] ? 66'(-p) : 66'(p);
    m   = (RndW-1)'((mag + 66'd32768) >> 16);
    return p[65] ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  function automatic ipu_c32_t clip32(input logic signed [WideW-1:0] v);
    ipu_c32_t r;
    r.sat = 1'b1;
    if (v > WideMidMax) begin
      r.val = 32'sh7fffffff;
    end else if (v < WideMidMin) begin
      r.val = 32'sh80000000;
    end else begin
      r.sat = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

  function automatic ipu_c20_t clip20(input logic signed [WideW-1:0] v);
    ipu_c20_t r;
    r.sat = 1'b1;
    if (v > WideOutMax) begin
      r.val = 20'sh7ffff;
    end else if (v < WideOutMin) begin
      r.val = 20'sh80000;
    end else begin
      r.sat = 1'b0;
      r.val = v[19:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hdl/ipu_div.sv
// ----------------------------------------------------------------------------
// ipu_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ipu_div import ipu_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               adv_i,
  input  wire logic [DivNumW-1:0] num_i,
  input  wire logic [DivDenW-1:0] den_i,
  output logic      [DivNumW-1:0] quo_o
);

  logic [DivDenW-1:0] rem_q [DivStages];
  logic [DivDenW-1:0] rem_d [DivStages];
  logic [DivNumW-1:0] num_q [DivStages];
  logic [DivNumW-1:0] num_d [DivStages];
  logic [DivNumW-1:0] quo_q [DivStages];
  logic [DivNumW-1:0] quo_d [DivStages];
  logic [DivDenW-1:0] den_q [DivStages];
  logic [DivDenW-1:0] den_d [DivStages];

  always_comb begin
    logic [DivDenW-1:0] prem;
    logic [DivNumW-1:0] pnum;
    logic [DivNumW-1:0] pquo;
    logic [DivDenW-1:0] pden;
    logic [DivDenW:0]   t;
    logic               ge;
    for (int s = 0; s < DivStages; s++) begin
      if (s == 0) begin
        prem = '0;
        pnum = num_i;
        pquo = '0;
        pden = den_i;
      end else begin
        prem = rem_q[s-1];
        pnum = num_q[s-1];
        pquo = quo_q[s-1];
        pden = den_q[s-1];
      end
      t        = {prem, pnum[DivNumW-1]};
      ge       = (t >= {1'b0, pden});
      rem_d[s] = ge ? DivDenW'(t - {1'b0, pden}) : t[DivDenW-1:0];
      num_d[s] = {pnum[DivNumW-2:0], 1'b0};
      quo_d[s] = {pquo[DivNumW-2:0], ge};
      den_d[s] = pden;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rem_q <= rem_d;
      num_q <= num_d;
      quo_q <= quo_d;
      den_q <= den_d;
    end
  end

  assign quo_o = quo_q[DivStages-1];

endmodule

`default_nettype wire

### hdl/ipu_norm.sv
// ----------------------------------------------------------------------------
// ipu_norm
// Pixel to normalized coordinate: (pixel - center) / focal, rounded, clamped.
// ----------------------------------------------------------------------------
`default_nettype none

module ipu_norm import ipu_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        adv_i,
  input  wire logic        vld_i,
  input  wire logic [15:0] pixel_x_i,
  input  wire logic [15:0] pixel_y_i,
  input  wire logic [15:0] center_x_i,
  input  wire logic [15:0] center_y_i,
  input  wire logic [15:0] focal_x_i,
  input  wire logic [15:0] focal_y_i,
  output ipu_item_t        item_o
);

  typedef struct packed {
    logic xneg;
    logic xzero;
    logic yneg;
    logic yzero;
  } norm_sb_t;

  logic signed [16:0] dx, dy;
  logic [15:0]        mx, my;
  logic [DivNumW-1:0] qx, qy;
  norm_sb_t           sb_d;
  norm_sb_t           sb_q [DivStages];
  logic [DivStages-1:0] vld_q;
  ipu_item_t          item_d, item_q;
  ipu_c20_t           cx, cy;

  assign dx = $signed({1'b0, pixel_x_i}) - $signed({1'b0, center_x_i});
  assign dy = $signed({1'b0, pixel_y_i}) - $signed({1'b0, center_y_i});
  assign mx = dx[16] ? 16'(-dx) : dx[15:0];
  assign my = dy[16] ? 16'(-dy) : dy[15:0];

  assign sb_d = '{xneg: dx[16], xzero: (dx == '0), yneg: dy[16], yzero: (dy == '0)};

  ipu_div u_div_x (
    .clk_i (clk_i),
    .adv_i (adv_i),
    .num_i ({1'b0, mx, 16'b0} + DivNumW'(focal_x_i >> 1)),
    .den_i (DivDenW'(focal_x_i)),
    .quo_o (qx)
  );

  ipu_div u_div_y (
    .clk_i (clk_i),
    .adv_i (adv_i),
    .num_i ({1'b0, my, 16'b0} + DivNumW'(focal_y_i >> 1)),
    .den_i (DivDenW'(focal_y_i)),
    .quo_o (qy)
  );

  // sign restore and clamp; zero focal saturates by sign of the offset
  function automatic ipu_c20_t finish(input logic [DivNumW-1:0] q, input logic neg,
                                      input logic zero, input logic fzero);
    ipu_c20_t r;
    logic signed [DivNumW:0] qs;
    qs = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    if (fzero) begin
      r.sat = !zero;
      r.val = zero ? 20'sd0 : (neg ? 20'sh80000 : 20'sh7ffff);
    end else begin
      r = clip20(WideW'(qs));
    end
    return r;
  endfunction

  always_comb begin
    norm_sb_t s;
    s          = sb_q[DivStages-1];
    cx         = finish(qx, s.xneg, s.xzero, focal_x_i == '0);
    cy         = finish(qy, s.yneg, s.yzero, focal_y_i == '0);
    item_d.vld = vld_q[DivStages-1];
    item_d.sat = cx.sat | cy.sat;
    item_d.xd  = cx.val;
    item_d.yd  = cy.val;
    item_d.x   = cx.val;
    item_d.y   = cy.val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      item_q <= '0;
    end else if (adv_i) begin
      vld_q  <= {vld_q[DivStages-2:0], vld_i};
      item_q <= item_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sb_q[0] <= sb_d;
      for (int s = 1; s < DivStages; s++) begin
        sb_q[s] <= sb_q[s-1];
      end
    end
  end

  assign item_o = item_q;

endmodule

`default_nettype wire

### hdl/ipu_iter.sv
// ----------------------------------------------------------------------------
// ipu_iter
// One unrolled refinement step of the radial-tangential inversion.
// ----------------------------------------------------------------------------
`default_nettype none

module ipu_iter import ipu_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      adv_i,
  input  wire ipu_coef_t coef_i,
  input  wire ipu_item_t item_i,
  output ipu_item_t      item_o
);

  typedef struct packed {
    logic               sat;
    logic signed [19:0] xd;
    logic signed [19:0] yd;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic               dneg;
    logic               dzero;
  } iter_sb_t;

  // valid bits: stages A..F, then H, I (J lives in j_q)
  logic [5:0]           pre_vld_q;
  logic [DivStages-1:0] div_vld_q;
  logic [1:0]           post_vld_q;

  // stage A: squares and cross term
  logic               a_sat;
  logic signed [19:0] a_xd, a_yd;
  logic signed [RndW-1:0] a_xx, a_yy, a_xy;
  // stage B: radius and tangential operands
  logic               b_sat;
  logic signed [19:0] b_xd, b_yd;
  logic signed [RndW-1:0] b_xy;
  logic signed [31:0] b_r2;
  logic signed [32:0] b_ax, b_ay;
  // stage C: products
  logic               c_sat;
  logic signed [19:0] c_xd, c_yd;
  logic signed [RndW-1:0] c_r4, c_k1r2, c_t1, c_t2, c_t3, c_t4;
  // stage D: clamps
  logic               d_sat;
  logic signed [19:0] d_xd, d_yd;
  logic signed [31:0] d_r4, d_tx, d_ty;
  logic signed [RndW-1:0] d_k1r2;
  // stage E: fourth order term, errors
  logic               e_sat;
  logic signed [19:0] e_xd, e_yd;
  logic signed [RndW-1:0] e_k1r2, e_k2r4;
  logic signed [31:0] e_ex, e_ey;
  // stage F: denominator
  logic               f_sat;
  logic signed [19:0] f_xd, f_yd;
  logic signed [31:0] f_den, f_ex, f_ey;
  // stage H: reciprocal
  logic               h_sat;
  logic signed [19:0] h_xd, h_yd;
  logic signed [31:0] h_ex, h_ey, h_kinv;
  // stage I: scaled errors
  logic               i_sat;
  logic signed [19:0] i_xd, i_yd;
  logic signed [RndW-1:0] i_px, i_py;
  // stage J: output
  ipu_item_t          j_q;

  ipu_c32_t b_r2c, d_r4c, d_txc, d_tyc, e_exc, e_eyc, f_denc, h_kc;
  ipu_c20_t j_xc, j_yc;

  logic [DivDenW-1:0] dmag;
  logic [DivNumW-1:0] quo;
  logic signed [DivNumW:0] qs;
  iter_sb_t sb_d, sb_o;
  iter_sb_t sb_q [DivStages];

  assign b_r2c  = clip32(WideW'(a_xx) + WideW'(a_yy));
  assign d_r4c  = clip32(WideW'(c_r4));
  assign d_txc  = clip32(WideW'(c_t1) + WideW'(c_t2));
  assign d_tyc  = clip32(WideW'(c_t3) + WideW'(c_t4));
  assign e_exc  = clip32(WideW'(d_xd) - WideW'(d_tx));
  assign e_eyc  = clip32(WideW'(d_yd) - WideW'(d_ty));
  assign f_denc = clip32(WideOne + WideW'(e_k1r2) + WideW'(e_k2r4));

  // divider feed: 2^32 / |den|, rounded by adding half the divisor
  assign dmag = f_den[31] ? DivDenW'(-f_den) : DivDenW'(f_den);
  assign sb_d = '{sat: f_sat, xd: f_xd, yd: f_yd, ex: f_ex, ey: f_ey,
                  dneg: f_den[31], dzero: (f_den == '0)};

  ipu_div u_div (
    .clk_i (clk_i),
    .adv_i (adv_i),
    .num_i ({1'b1, 32'b0} + DivNumW'(dmag >> 1)),
    .den_i (dmag),
    .quo_o (quo)
  );

  assign sb_o = sb_q[DivStages-1];
  assign qs   = sb_o.dneg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  // zero denominator pins the reciprocal at the positive limit
  assign h_kc = sb_o.dzero ? ipu_c32_t'{sat: 1'b1, val: 32'sh7fffffff}
                           : clip32(WideW'(qs));

  assign j_xc = clip20(WideW'(i_px));
  assign j_yc = clip20(WideW'(i_py));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_vld_q  <= '0;
      div_vld_q  <= '0;
      post_vld_q <= '0;
      j_q        <= '0;
    end else if (adv_i) begin
      pre_vld_q  <= {pre_vld_q[4:0], item_i.vld};
      div_vld_q  <= {div_vld_q[DivStages-2:0], pre_vld_q[5]};
      post_vld_q <= {post_vld_q[0], div_vld_q[DivStages-1]};
      // J
      j_q.vld    <= post_vld_q[1];
      j_q.sat    <= i_sat | j_xc.sat | j_yc.sat;
      j_q.xd     <= i_xd;
      j_q.yd     <= i_yd;
      j_q.x      <= j_xc.val;
      j_q.y      <= j_yc.val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      // A
      a_sat <= item_i.sat;
      a_xd  <= item_i.xd;
      a_yd  <= item_i.yd;
      a_xx  <= mulq(33'(item_i.x), 33'(item_i.x));
      a_yy  <= mulq(33'(item_i.y), 33'(item_i.y));
      a_xy  <= mulq(33'(item_i.x), 33'(item_i.y));
      // B
      b_sat <= a_sat | b_r2c.sat;
      b_xd  <= a_xd;
      b_yd  <= a_yd;
      b_xy  <= a_xy;
      b_r2  <= b_r2c.val;
      b_ax  <= 33'(b_r2c.val) + 33'(a_xx <<< 1);
      b_ay  <= 33'(b_r2c.val) + 33'(a_yy <<< 1);
      // C
      c_sat  <= b_sat;
      c_xd   <= b_xd;
      c_yd   <= b_yd;
      c_r4   <= mulq(33'(b_r2), 33'(b_r2));
      c_k1r2 <= mulq(33'(coef_i.k1), 33'(b_r2));
      c_t1   <= mulq(33'($signed({coef_i.p1, 1'b0})), 33'(b_xy));
      c_t2   <= mulq(33'(coef_i.p2), b_ax);
      c_t3   <= mulq(33'($signed({coef_i.p2, 1'b0})), 33'(b_xy));
      c_t4   <= mulq(33'(coef_i.p1), b_ay);
      // D
      d_sat  <= c_sat | d_r4c.sat | d_txc.sat | d_tyc.sat;
      d_xd   <= c_xd;
      d_yd   <= c_yd;
      d_r4   <= d_r4c.val;
      d_tx   <= d_txc.val;
      d_ty   <= d_tyc.val;
      d_k1r2 <= c_k1r2;
      // E
      e_sat  <= d_sat | e_exc.sat | e_eyc.sat;
      e_xd   <= d_xd;
      e_yd   <= d_yd;
      e_k1r2 <= d_k1r2;
      e_k2r4 <= mulq(33'(coef_i.k2), 33'(d_r4));
      e_ex   <= e_exc.val;
      e_ey   <= e_eyc.val;
      // F
      f_sat <= e_sat | f_denc.sat;
      f_xd  <= e_xd;
      f_yd  <= e_yd;
      f_den <= f_denc.val;
      f_ex  <= e_ex;
      f_ey  <= e_ey;
      // divider sideband
      sb_q[0] <= sb_d;
      for (int s = 1; s < DivStages; s++) begin
        sb_q[s] <= sb_q[s-1];
      end
      // H
      h_sat  <= sb_o.sat | h_kc.sat;
      h_xd   <= sb_o.xd;
      h_yd   <= sb_o.yd;
      h_ex   <= sb_o.ex;
      h_ey   <= sb_o.ey;
      h_kinv <= h_kc.val;
      // I
      i_sat <= h_sat;
      i_xd  <= h_xd;
      i_yd  <= h_yd;
      i_px  <= mulq(33'(h_ex), 33'(h_kinv));
      i_py  <= mulq(33'(h_ey), 33'(h_kinv));
    end
  end

  assign item_o = j_q;

endmodule

`default_nettype wire

### hdl/iterative_point_undistortion_core.sv
// ----------------------------------------------------------------------------
// iterative_point_undistortion_core
// Pixel to undistorted normalized coordinate, radial-tangential lens model.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one distorted pixel pair in
//   unsigned Q11.5. Output channel (out_valid_o / out_stall_i) returns the
//   undistorted normalized pair in signed Q3.16 plus a saturated flag.
//   An item moves when valid is high and stall is low.
//   Throughput: one item per cycle, sustained while the output is not stalled.
//   Structure: normalization (33-stage divider plus clamp), then five
//   refinement steps of six arithmetic stages, a 33-stage reciprocal
//   divider and three stages of scale and clamp. The dividers resolve
//   one quotient bit per stage.
//   Stall: the whole pipeline freezes while a result waits at the output
//   and out_stall_i is high; in_stall_o follows, nothing is dropped or sent
//   twice. Empty slots do not stall the input.
//   Reset: all valid bits clear; config and output registers take reset values.
//   Configuration is written through cfg_we_i / cfg_index_i / cfg_data_i
//   while no item is in flight; the write takes effect at once.
// ----------------------------------------------------------------------------
`default_nettype none

module iterative_point_undistortion_core import ipu_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [19:0]        cfg_data_i,
  // input items
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [15:0]        pixel_x_i,
  input  wire logic [15:0]        pixel_y_i,
  // result items
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [19:0]      norm_x_o,
  output logic signed [19:0]      norm_y_o,
  output logic                    saturated_o
);

  logic [15:0] center_x_q, center_y_q, focal_x_q, focal_y_q;
  ipu_coef_t   coef_q;
  logic        adv;
  ipu_item_t   chain [0:Iterations];

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= 16'd10240;
      center_y_q <= 16'd7680;
      focal_x_q  <= 16'd12800;
      focal_y_q  <= 16'd12800;
      coef_q     <= '0;
    end else if (cfg_we_i) begin
      case (ipu_reg_e'(cfg_index_i))
        RegCenterX: begin
          center_x_q <= cfg_data_i[15:0];
        end
        RegCenterY: begin
          center_y_q <= cfg_data_i[15:0];
        end
        RegFocalX: begin
          focal_x_q <= cfg_data_i[15:0];
        end
        RegFocalY: begin
          focal_y_q <= cfg_data_i[15:0];
        end
        RegK1: begin
          coef_q.k1 <= cfg_data_i;
        end
        RegK2: begin
          coef_q.k2 <= cfg_data_i;
        end
        RegP1: begin
          coef_q.p1 <= cfg_data_i;
        end
        RegP2: begin
          coef_q.p2 <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  // global advance: only a held result freezes the line
  assign adv        = !(chain[Iterations].vld && out_stall_i);
  assign in_stall_o = !adv;

  ipu_norm u_norm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .vld_i      (in_valid_i),
    .pixel_x_i  (pixel_x_i),
    .pixel_y_i  (pixel_y_i),
    .center_x_i (center_x_q),
    .center_y_i (center_y_q),
    .focal_x_i  (focal_x_q),
    .focal_y_i  (focal_y_q),
    .item_o     (chain[0])
  );

  // unrolled refinement steps
  for (genvar i = 0; i < Iterations; i++) begin : g_iter
    ipu_iter u_iter (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .coef_i (coef_q),
      .item_i (chain[i]),
      .item_o (chain[i+1])
    );
  end

  assign out_valid_o = chain[Iterations].vld;
  assign norm_x_o    = chain[Iterations].x;
  assign norm_y_o    = chain[Iterations].y;
  assign saturated_o = chain[Iterations].sat;

  // a waiting result must hold the input back
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("result waiting but input not stalled");

  // frozen pipeline keeps its output valid
  a_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(out_valid_o))
    else $error("output valid changed while pipeline frozen");

  // an empty output slot never stalls the input
  a_no_bubble_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

endmodule

`default_nettype wire

### dv/iterative_point_undistortion_checker.sv
// ----------------------------------------------------------------------------
// iterative_point_undistortion_checker
// Watches both item channels and the register port, computes the undistorted
// coordinate of every accepted pixel pair and compares it with the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iterative_point_undistortion_checker import ipu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [19:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_o,
  input  logic [15:0]        pixel_x_i,
  input  logic [15:0]        pixel_y_i,
  input  logic               out_valid_o,
  input  logic               out_stall_i,
  input  logic signed [19:0] norm_x_o,
  input  logic signed [19:0] norm_y_o,
  input  logic               saturated_o,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 result_count_o,
  output int                 sat_count_o
);

  typedef struct {
    logic signed [19:0] nx;
    logic signed [19:0] ny;
    logic               sat;
  } point_t;

  localparam longint QOne   = 65536;
  localparam longint OutLo  = -524288;
  localparam longint OutHi  = 524287;
  localparam longint MidLo  = -64'sd2147483648;
  localparam longint MidHi  = 2147483647;
  localparam longint HugeQ  = 64'sd1 << 40;

  longint cx, cy, fx, fy, k1, k2, p1, p2;
  point_t expected_points[$];

  // append one predicted point at the tail of the queue
  function automatic void enqueue_point(point_t p);
    expected_points.insert(expected_points.size(), p);
  endfunction

  function automatic longint clampq(longint v, longint lo, longint hi, ref bit f);
    if (v < lo) begin
      f = 1;
      return lo;
    end
    if (v > hi) begin
      f = 1;
      return hi;
    end
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    longint p;
    longint m;
    p = a * b;
    m = ((p < 0 ? -p : p) + 32768) >>> 16;
    return p < 0 ? -m : m;
  endfunction

  function automatic longint qdiv(longint n, longint d);
    longint an;
    longint ad;
    longint q;
    if (n == 0) return 0;
    if (d == 0) return n < 0 ? -HugeQ : HugeQ;
    an = n < 0 ? -n : n;
    ad = d < 0 ? -d : d;
    q = (an + ad / 2) / ad;
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  function automatic point_t undistort(logic [15:0] px, logic [15:0] py);
    point_t r;
    bit s;
    longint xd, yd, x, y, xx, yy, xy, r2, r4, den, kinv, tx, ty, ex, ey;
    s = 0;
    xd = clampq(qdiv((longint'(px) - cx) * QOne, fx), OutLo, OutHi, s);
    yd = clampq(qdiv((longint'(py) - cy) * QOne, fy), OutLo, OutHi, s);
    x = xd;
    y = yd;
    for (int i = 0; i < Iterations; i++) begin
      xx = qmul(x, x);
      yy = qmul(y, y);
      xy = qmul(x, y);
      r2 = clampq(xx + yy, MidLo, MidHi, s);
      r4 = clampq(qmul(r2, r2), MidLo, MidHi, s);
      den = clampq(QOne + qmul(k1, r2) + qmul(k2, r4), MidLo, MidHi, s);
      kinv = clampq(qdiv(QOne * QOne, den), MidLo, MidHi, s);
      tx = clampq(qmul(2 * p1, xy) + qmul(p2, r2 + 2 * xx), MidLo, MidHi, s);
      ty = clampq(qmul(2 * p2, xy) + qmul(p1, r2 + 2 * yy), MidLo, MidHi, s);
      ex = clampq(xd - tx, MidLo, MidHi, s);
      ey = clampq(yd - ty, MidLo, MidHi, s);
      x = clampq(qmul(ex, kinv), OutLo, OutHi, s);
      y = clampq(qmul(ey, kinv), OutLo, OutHi, s);
    end
    r.nx = x[19:0];
    r.ny = y[19:0];
    r.sat = s;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    point_t e;
    if (!rst_ni) begin
      cx = 10240; cy = 7680; fx = 12800; fy = 12800;
      k1 = 0; k2 = 0; p1 = 0; p2 = 0;
      expected_points.delete();
      fail_count_o = 0;
      result_count_o = 0;
      sat_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (ipu_reg_e'(cfg_index_i))
          RegCenterX: cx = cfg_data_i[15:0];
          RegCenterY: cy = cfg_data_i[15:0];
          RegFocalX:  fx = cfg_data_i[15:0];
          RegFocalY:  fy = cfg_data_i[15:0];
          RegK1:      k1 = longint'(signed'(cfg_data_i));
          RegK2:      k2 = longint'(signed'(cfg_data_i));
          RegP1:      p1 = longint'(signed'(cfg_data_i));
          RegP2:      p2 = longint'(signed'(cfg_data_i));
          default: ;
        endcase
      end
      if (out_valid_o && !out_stall_i) begin
        result_count_o++;
        if (expected_points.size() == 0) begin
          $error("unexpected result x=%0d y=%0d", norm_x_o, norm_y_o);
          fail_count_o++;
        end else begin
          e = expected_points.pop_front();
          if (e.sat) sat_count_o++;
          if (norm_x_o !== e.nx) begin
            $error("norm_x expected %0d actual %0d", e.nx, norm_x_o);
            fail_count_o++;
          end
          if (norm_y_o !== e.ny) begin
            $error("norm_y expected %0d actual %0d", e.ny, norm_y_o);
            fail_count_o++;
          end
          if (saturated_o !== e.sat) begin
            $error("saturated expected %0b actual %0b", e.sat, saturated_o);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) enqueue_point(undistort(pixel_x_i, pixel_y_i));
    end
    pending_o = expected_points.size();
  end

endmodule

### dv/iterative_point_undistortion_core_test.sv
// ----------------------------------------------------------------------------
// iterative_point_undistortion_core_test
// Drives pixel pairs through the undistortion core under several lens and
// camera settings, with random idling on both channels; a checker beside the
// core predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iterative_point_undistortion_core_test import ipu_pkg::*;;

  localparam int Latency  = 244;
  localparam int Watchdog = 5000;  // idle cycles; well above latency + stalls

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [2:0] cfg_index_i = RegCenterX;
  logic [19:0] cfg_data_i = 0;
  logic in_valid_i = 0;
  logic in_stall_o;
  logic [15:0] pixel_x_i = 0;
  logic [15:0] pixel_y_i = 0;
  logic out_valid_o;
  logic out_stall_i = 0;
  logic signed [19:0] norm_x_o;
  logic signed [19:0] norm_y_o;
  logic saturated_o;
  int fail_count, pending, result_count, sat_count;
  int idle_cycles = 0;
  int phases_done = 0;
  bit quiet = 0;  // no idling in the tail of the run

  always #5 clk_i = ~clk_i;

  iterative_point_undistortion_core uut (.*);

  iterative_point_undistortion_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .pixel_x_i, .pixel_y_i,
    .out_valid_o, .out_stall_i, .norm_x_o, .norm_y_o, .saturated_o,
    .fail_count_o(fail_count), .pending_o(pending),
    .result_count_o(result_count), .sat_count_o(sat_count)
  );

  // watchdog: cycles without any accepted item on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= Watchdog) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // receiver stalls in random bursts
  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 15);
        out_stall_i <= 1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i <= 0;
    end
  end

  task automatic write_reg(ipu_reg_e idx, logic [19:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 0;
  endtask

  // hold items until the pipe is empty, then let it settle
  task automatic drain();
    wait (pending == 0);
    repeat (Latency + 10) @(negedge clk_i);
  endtask

  // one pixel pair through the handshake; sender gaps come in bursts
  task automatic send_pixel(logic [15:0] px, logic [15:0] py);
    int n;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 15);
      in_valid_i <= 0;
      repeat (n) @(negedge clk_i);
    end
    in_valid_i <= 1;
    pixel_x_i <= px;
    pixel_y_i <= py;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic stop_sending();
    in_valid_i <= 0;
  endtask

  // set lens and camera; k values are small Q3.16 unless extreme
  task automatic set_camera(logic [15:0] x0, logic [15:0] y0, logic [15:0] f0,
                            logic [15:0] f1, logic [19:0] a, logic [19:0] b,
                            logic [19:0] c, logic [19:0] d);
    write_reg(RegCenterX, {4'd0, x0});
    write_reg(RegCenterY, {4'd0, y0});
    write_reg(RegFocalX, {4'd0, f0});
    write_reg(RegFocalY, {4'd0, f1});
    write_reg(RegK1, a);
    write_reg(RegK2, b);
    write_reg(RegP1, c);
    write_reg(RegP2, d);
    phases_done++;
  endtask

  // random point near the center most of the time, anywhere otherwise
  task automatic random_points(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) != 0) begin
        send_pixel(16'(10240 + $urandom_range(0, 16383) - 8192),
                   16'(7680 + $urandom_range(0, 16383) - 8192));
      end else begin
        send_pixel(16'($urandom), 16'($urandom));
      end
    end
    stop_sending();
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1;

    // directed: reset camera, corners, center, bit patterns
    send_pixel(16'd10240, 16'd7680);
    send_pixel(16'd0, 16'd0);
    send_pixel(16'hffff, 16'hffff);
    send_pixel(16'd0, 16'hffff);
    send_pixel(16'hffff, 16'd0);
    send_pixel(16'haaaa, 16'h5555);
    send_pixel(16'h5555, 16'haaaa);
    stop_sending();
    drain();

    // smallest focal lengths force clamping of the start value
    set_camera(16'd0, 16'hffff, 16'd32, 16'd32, 20'd0, 20'd0, 20'd0, 20'd0);
    send_pixel(16'd0, 16'hffff);
    send_pixel(16'hffff, 16'd0);
    send_pixel(16'd40, 16'hfff0);
    stop_sending();
    drain();

    // k1 = -1: denominator hits zero at r2 = 1; negative beyond
    set_camera(16'd10240, 16'd7680, 16'd12800, 16'd12800,
               -20'sd65536, 20'd0, 20'd0, 20'd0);
    send_pixel(16'd10240 + 16'd12800, 16'd7680);
    send_pixel(16'd10240 + 16'd25600, 16'd7680);
    send_pixel(16'd10240, 16'd7680 + 16'd6400);
    stop_sending();
    drain();

    // coefficient extremes
    set_camera(16'hffff, 16'd0, 16'hffff, 16'hffff,
               20'h7ffff, 20'h80000, 20'h7ffff, 20'h80000);
    send_pixel(16'd0, 16'hffff);
    send_pixel(16'hffff, 16'd0);
    send_pixel(16'h8000, 16'h8000);
    stop_sending();
    drain();
    set_camera(16'd0, 16'd0, 16'd32, 16'hffff,
               20'h80000, 20'h7ffff, 20'h80000, 20'h7ffff);
    send_pixel(16'h1234, 16'hfedc);
    send_pixel(16'hffff, 16'hffff);
    stop_sending();
    drain();

    // random phases, mild realistic lenses and wild ones
    for (int ph = 0; ph < 6; ph++) begin
      if (ph % 2 == 0) begin
        set_camera(16'($urandom_range(8000, 12000)), 16'($urandom_range(6000, 9000)),
                   16'($urandom_range(8000, 20000)), 16'($urandom_range(8000, 20000)),
                   20'($urandom_range(0, 40000) - 20000),
                   20'($urandom_range(0, 20000) - 10000),
                   20'($urandom_range(0, 2000) - 1000),
                   20'($urandom_range(0, 2000) - 1000));
      end else begin
        set_camera(16'($urandom), 16'($urandom), 16'($urandom_range(32, 65535)),
                   16'($urandom_range(32, 65535)), 20'($urandom), 20'($urandom),
                   20'($urandom), 20'($urandom));
      end
      random_points(200);
      drain();
    end

    // tail: reset camera, full rate, no idling on either side
    set_camera(16'd10240, 16'd7680, 16'd12800, 16'd12800,
               20'd3000, -20'sd1500, 20'd200, -20'sd300);
    quiet = 1;
    random_points(160);
    wait (pending == 0);
    repeat (Latency + 10) @(negedge clk_i);

    $display("Covered %0d results over %0d camera settings, %0d of them saturated.",
             result_count, phases_done, sat_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
